@@ src/macroman_utf8_transcoder_core_macros.svh @@
// Assertion macros for the Mac Roman / UTF-8 transcoder.
`ifndef MACROMAN_UTF8_TRANSCODER_CORE_MACROS_SVH
`define MACROMAN_UTF8_TRANSCODER_CORE_MACROS_SVH

// Assert that a property holds on every clock edge outside reset.
`define MRU_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Assert that an antecedent implies a consequent in the next cycle.
`define MRU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/mru_pkg.sv @@
// Package with the Mac Roman upper-half table and lookup functions.
`timescale 1ns / 1ps
`default_nettype none
package mru_pkg;

  localparam logic DIR_TO_UTF8  = 1'b0;
  localparam logic DIR_TO_ROMAN = 1'b1;
  localparam logic [7:0] CHAR_QUESTION = 8'h3F;

  function automatic logic [15:0] upper_code(input logic [6:0] idx);
    logic [15:0] c;
    unique case (idx)
      7'd0: c = 16'h00C4; 7'd1: c = 16'h00C5; 7'd2: c = 16'h00C7; 7'd3: c = 16'h00C9;
      7'd4: c = 16'h00D1; 7'd5: c = 16'h00D6; 7'd6: c = 16'h00DC; 7'd7: c = 16'h00E1;
      7'd8: c = 16'h00E0; 7'd9: c = 16'h00E2; 7'd10: c = 16'h00E4; 7'd11: c = 16'h00E3;
      7'd12: c = 16'h00E5; 7'd13: c = 16'h00E7; 7'd14: c = 16'h00E9; 7'd15: c = 16'h00E8;
      7'd16: c = 16'h00EA; 7'd17: c = 16'h00EB; 7'd18: c = 16'h00ED; 7'd19: c = 16'h00EC;
      7'd20: c = 16'h00EE; 7'd21: c = 16'h00EF; 7'd22: c = 16'h00F1; 7'd23: c = 16'h00F3;
      7'd24: c = 16'h00F2; 7'd25: c = 16'h00F4; 7'd26: c = 16'h00F6; 7'd27: c = 16'h00F5;
      7'd28: c = 16'h00FA; 7'd29: c = 16'h00F9; 7'd30: c = 16'h00FB; 7'd31: c = 16'h00FC;
      7'd32: c = 16'h2020; 7'd33: c = 16'h00B0; 7'd34: c = 16'h00A2; 7'd35: c = 16'h00A3;
      7'd36: c = 16'h00A7; 7'd37: c = 16'h2022; 7'd38: c = 16'h00B6; 7'd39: c = 16'h00DF;
      7'd40: c = 16'h00AE; 7'd41: c = 16'h00A9; 7'd42: c = 16'h2122; 7'd43: c = 16'h00B4;
      7'd44: c = 16'h00A8; 7'd45: c = 16'h2260; 7'd46: c = 16'h00C6; 7'd47: c = 16'h00D8;
      7'd48: c = 16'h221E; 7'd49: c = 16'h00B1; 7'd50: c = 16'h2264; 7'd51: c = 16'h2265;
      7'd52: c = 16'h00A5; 7'd53: c = 16'h00B5; 7'd54: c = 16'h2202; 7'd55: c = 16'h2211;
      7'd56: c = 16'h220F; 7'd57: c = 16'h03C0; 7'd58: c = 16'h222B; 7'd59: c = 16'h00AA;
      7'd60: c = 16'h00BA; 7'd61: c = 16'h03A9; 7'd62: c = 16'h00E6; 7'd63: c = 16'h00F8;
      7'd64: c = 16'h00BF; 7'd65: c = 16'h00A1; 7'd66: c = 16'h00AC; 7'd67: c = 16'h221A;
      7'd68: c = 16'h0192; 7'd69: c = 16'h2248; 7'd70: c = 16'h2206; 7'd71: c = 16'h00AB;
      7'd72: c = 16'h00BB; 7'd73: c = 16'h2026; 7'd74: c = 16'h00A0; 7'd75: c = 16'h00C0;
      7'd76: c = 16'h00C3; 7'd77: c = 16'h00D5; 7'd78: c = 16'h0152; 7'd79: c = 16'h0153;
      7'd80: c = 16'h2013; 7'd81: c = 16'h2014; 7'd82: c = 16'h201C; 7'd83: c = 16'h201D;
      7'd84: c = 16'h2018; 7'd85: c = 16'h2019; 7'd86: c = 16'h00F7; 7'd87: c = 16'h25CA;
      7'd88: c = 16'h00FF; 7'd89: c = 16'h0178; 7'd90: c = 16'h2044; 7'd91: c = 16'h20AC;
      7'd92: c = 16'h2039; 7'd93: c = 16'h203A; 7'd94: c = 16'hFB01; 7'd95: c = 16'hFB02;
      7'd96: c = 16'h2021; 7'd97: c = 16'h00B7; 7'd98: c = 16'h201A; 7'd99: c = 16'h201E;
      7'd100: c = 16'h2030; 7'd101: c = 16'h00C2; 7'd102: c = 16'h00CA; 7'd103: c = 16'h00C1;
      7'd104: c = 16'h00CB; 7'd105: c = 16'h00C8; 7'd106: c = 16'h00CD; 7'd107: c = 16'h00CE;
      7'd108: c = 16'h00CF; 7'd109: c = 16'h00CC; 7'd110: c = 16'h00D3; 7'd111: c = 16'h00D4;
      7'd112: c = 16'hF8FF; 7'd113: c = 16'h00D2; 7'd114: c = 16'h00DA; 7'd115: c = 16'h00DB;
      7'd116: c = 16'h00D9; 7'd117: c = 16'h0131; 7'd118: c = 16'h02C6; 7'd119: c = 16'h02DC;
      7'd120: c = 16'h00AF; 7'd121: c = 16'h02D8; 7'd122: c = 16'h02D9; 7'd123: c = 16'h02DA;
      7'd124: c = 16'h00B8; 7'd125: c = 16'h02DD; 7'd126: c = 16'h02DB; 7'd127: c = 16'h02C7;
      default: c = 16'h0000;
    endcase
    return c;
  endfunction

  // Reverse lookup: a compare against each of the 128 constant entries runs in
  // parallel; the entries are distinct so at most one matches.
  function automatic logic [7:0] code_to_roman(input logic [15:0] cp);
    logic [7:0] r;
    r = CHAR_QUESTION;
    if (cp <= 16'h007F) begin
      r = cp[7:0];
    end else begin
      for (int i = 0; i < 128; i++) begin
        if (upper_code(7'(i)) == cp) r = 8'(8'h80 + i);
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

@@ src/mru_decode.sv @@
// Combinational conversion of one source byte into up to three result bytes.
`timescale 1ns / 1ps
`default_nettype none
module mru_decode (
  input  wire logic        direction,
  input  wire logic [7:0]  in_byte,
  input  wire logic [1:0]  bytes_pending,
  input  wire logic [15:0] partial_code,
  output logic [1:0]  count,
  output logic [23:0] bytes,
  output logic [1:0]  bytes_pending_next,
  output logic [15:0] partial_code_next
);

  logic [15:0] c;
  logic [15:0] cp;

  always_comb begin
    count = 2'd0;
    bytes = '0;
    bytes_pending_next = bytes_pending;
    partial_code_next = partial_code;
    c = in_byte[7] ? mru_pkg::upper_code(in_byte[6:0]) : {8'h00, in_byte};
    cp = partial_code | {10'd0, in_byte[5:0]};
    if (in_byte == 8'h00) begin
      bytes_pending_next = 2'd0;
      partial_code_next = '0;
    end else if (direction == mru_pkg::DIR_TO_UTF8) begin
      if (c < 16'h0080) begin
        count = 2'd1;
        bytes[7:0] = c[7:0];
      end else if (c < 16'h0800) begin
        count = 2'd2;
        bytes[7:0] = 8'hC0 | {3'd0, c[10:6]};
        bytes[15:8] = {2'b10, c[5:0]};
      end else begin
        count = 2'd3;
        bytes[7:0] = {4'hE, c[15:12]};
        bytes[15:8] = {2'b10, c[11:6]};
        bytes[23:16] = {2'b10, c[5:0]};
      end
    end else if (bytes_pending == 2'd0) begin
      if (!in_byte[7]) begin
        count = 2'd1;
        bytes[7:0] = in_byte;
      end else if (in_byte < 8'hE0) begin
        partial_code_next = {5'd0, in_byte[4:0], 6'd0};
        bytes_pending_next = 2'd1;
      end else begin
        partial_code_next = {in_byte[3:0], 12'd0};
        bytes_pending_next = 2'd2;
      end
    end else if (bytes_pending == 2'd1) begin
      count = 2'd1;
      bytes[7:0] = mru_pkg::code_to_roman(cp);
      bytes_pending_next = 2'd0;
      partial_code_next = '0;
    end else begin
      partial_code_next = partial_code | {4'd0, in_byte[5:0], 6'd0};
      bytes_pending_next = 2'd1;
    end
  end

endmodule
`default_nettype wire

@@ src/macroman_utf8_transcoder_core.sv @@
// Top level of the Mac Roman / UTF-8 byte-stream transcoder.
// The first result byte of an item is registered and appears on the output in the
// cycle after the item is accepted. One output byte per cycle while m_tready holds;
// a new item is taken only once any bytes of the last one (up to three) are leaving.
// Reset (rst, synchronous, active high) clears direction, decoder state, output valid
// and the queued byte count; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
`include "macroman_utf8_transcoder_core_macros.svh"
module macroman_utf8_transcoder_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  wire logic        s_tvalid,
  output logic        s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] in_byte
  output logic        m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]  m_tdata,        // [7:0] out_byte
  output logic        m_tlast         // last_of_run
);

  localparam logic [2:0] ADDR_DIRECTION = 3'd0;

  logic        direction;
  logic [1:0]  bytes_pending;
  logic [15:0] partial_code;

  // Holding buffer: the current byte sits in m_tdata; up to two more queue in
  // rest with rest_count of them remaining.
  logic [15:0] rest;
  logic [1:0]  rest_count;

  logic [1:0]  count;
  logic [23:0] bytes;
  logic [1:0]  bytes_pending_next;
  logic [15:0] partial_code_next;
  logic        in_acc;
  logic        out_acc;
  logic        cfg_wr;

  mru_decode u_decode (
    .direction          (direction),
    .in_byte            (s_tdata),
    .bytes_pending      (bytes_pending),
    .partial_code       (partial_code),
    .count              (count),
    .bytes              (bytes),
    .bytes_pending_next (bytes_pending_next),
    .partial_code_next  (partial_code_next)
  );

  assign pready  = 1'b1;
  assign prdata  = {31'd0, direction};
  assign cfg_wr  = psel && penable && pwrite && (paddr == ADDR_DIRECTION);
  assign out_acc = m_tvalid && m_tready;
  // A new item is taken once the last byte in flight leaves this cycle, or when
  // the output is empty.
  assign s_tready = (rest_count == 2'd0) && (!m_tvalid || m_tready);
  assign in_acc = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      direction     <= mru_pkg::DIR_TO_UTF8;
      bytes_pending <= 2'd0;
      partial_code  <= '0;
      m_tvalid      <= 1'b0;
      rest_count    <= 2'd0;
    end else begin
      if (cfg_wr) begin
        direction     <= pwdata[0];
        bytes_pending <= 2'd0;
        partial_code  <= '0;
      end else if (in_acc) begin
        bytes_pending <= bytes_pending_next;
        partial_code  <= partial_code_next;
      end
      if (in_acc) begin
        m_tvalid   <= (count != 2'd0);
        m_tdata    <= bytes[7:0];
        m_tlast    <= (count == 2'd1);
        rest       <= bytes[23:8];
        rest_count <= (count == 2'd0) ? 2'd0 : 2'(count - 2'd1);
      end else if (out_acc) begin
        if (rest_count != 2'd0) begin
          m_tdata    <= rest[7:0];
          m_tlast    <= (rest_count == 2'd1);
          rest       <= {8'd0, rest[15:8]};
          rest_count <= 2'(rest_count - 2'd1);
        end else begin
          m_tvalid <= 1'b0;
        end
      end
    end
  end

  `MRU_ASSERT(a_rest_valid, (rest_count == 2'd0) || m_tvalid, "queued bytes without valid output")
  `MRU_ASSERT(a_last_match, !m_tvalid || (m_tlast == (rest_count == 2'd0)), "tlast out of step")
  `MRU_ASSERT_NEXT(a_pend_utf8, direction == mru_pkg::DIR_TO_UTF8, bytes_pending == 2'd0 || direction, "pending in utf8 mode")

endmodule
`default_nettype wire
